### src/clse_pkg.sv
// Shared types and fixed-point constants for the column log-sum-exp block.
package clse_pkg;

  localparam int IFRAC = 30;
  localparam int EXP_TERMS = 14;
  localparam int LOG_TERMS = 10;

  localparam logic [31:0] ONE_Q = 32'h4000_0000;
  localparam logic [31:0] LN2_Q = 32'd744261118;

  // Divider request; width of the dividend to walk through, in bits.
  typedef struct packed {
    logic       start;
    logic [6:0] nbits;
  } div_req_t;

  // 2^30 / (2j+1), truncated, for the odd-power log series.
  function automatic logic [31:0] log_coef(input logic [3:0] j);
    logic [31:0] c;
    case (j)
      4'd0:    c = 32'd1073741824;
      4'd1:    c = 32'd357913941;
      4'd2:    c = 32'd214748364;
      4'd3:    c = 32'd153391689;
      4'd4:    c = 32'd119304647;
      4'd5:    c = 32'd97612893;
      4'd6:    c = 32'd82595524;
      4'd7:    c = 32'd71582788;
      4'd8:    c = 32'd63161283;
      4'd9:    c = 32'd56512727;
      4'd10:   c = 32'd51130563;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

  // ceil(2^s / n) with s = 31 + ceil(log2 n); multiplying and shifting by s gives the
  // exact floor of x / n for any x below 2^31.
  function automatic logic [31:0] recip_mul(input logic [3:0] n);
    logic [31:0] m;
    case (n)
      4'd1:    m = 32'd2147483648;
      4'd2:    m = 32'd2147483648;
      4'd3:    m = 32'd2863311531;
      4'd4:    m = 32'd2147483648;
      4'd5:    m = 32'd3435973837;
      4'd6:    m = 32'd2863311531;
      4'd7:    m = 32'd2454267027;
      4'd8:    m = 32'd2147483648;
      4'd9:    m = 32'd3817748708;
      4'd10:   m = 32'd3435973837;
      4'd11:   m = 32'd3123612579;
      4'd12:   m = 32'd2863311531;
      4'd13:   m = 32'd2643056798;
      4'd14:   m = 32'd2454267027;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] recip_shift(input logic [3:0] n);
    logic [5:0] sh;
    if (n == 4'd1) begin
      sh = 6'd31;
    end else if (n == 4'd2) begin
      sh = 6'd32;
    end else if (n inside {4'd3, 4'd4}) begin
      sh = 6'd33;
    end else if (n inside {[4'd5:4'd8]}) begin
      sh = 6'd34;
    end else begin
      sh = 6'd35;
    end
    return sh;
  endfunction

endpackage

### src/clse_mul.sv
// Registered 32 by 32 unsigned multiplier shared by the sequencer.
module clse_mul
  import clse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod,
  output logic        done
);

  logic [63:0] prod_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= go;
    end
    prod_r <= 64'(a) * 64'(b);
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

### src/clse_div.sv
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
module clse_div
  import clse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quo,
  output logic        done
);

  logic [63:0] q_r;
  logic [31:0] rem_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic [33:0] trial;
  logic        ge;

  always_comb begin
    trial = {1'b0, rem_r, q_r[63]} - {2'b00, divisor};
    ge    = !trial[33];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r   <= dividend << (7'd64 - req.nbits);
        rem_r <= '0;
        cnt_r <= req.nbits;
      end else if (cnt_r != 7'd0) begin
        rem_r <= ge ? trial[31:0] : {rem_r[30:0], q_r[63]};
        q_r   <= {q_r[62:0], ge};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

### src/column_log_sum_exp_top.sv
// Column log-sum-exp reduction: sequencer around a shared multiplier and divider.
// A log-zero element is skipped; a contributing element goes through a reciprocal range
// reduction by ln 2 and fourteen Horner steps, each two multiplies on the shared
// multiplier. The last element then adds normalization, one 64-bit division and the log
// series. One item at a time; synchronous active-low reset clears the accumulator, flags
// and the sequencer.
module column_log_sum_exp_top
  import clse_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int ACC_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_element_value,
  input  logic signed [31:0] in_column_shift,
  input  logic               in_is_log_zero,
  input  logic               in_last_in_column,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_log_sum,
  output logic               out_column_empty,
  output logic               out_sum_saturated
);

  // Shift between the internal Q30 format and the port format.
  localparam int RS = IFRAC - FRAC_BITS;
  localparam logic [63:0] FRAC_LN2 = 64'(FRAC_BITS) * 64'(LN2_Q);
  localparam logic [64:0] ACC_MAX65 = 65'({ACC_WIDTH{1'b1}});
  localparam logic [6:0]  TOP_P = 7'(ACC_WIDTH - 1);

  // Range reduction: the difference in Q30 is offset by OFFQ * ln 2 so that it stays
  // positive and below 2^(TSH+32). The quotient by ln 2 is estimated from the top 32 bits
  // times a reciprocal; the estimate is at most one short, and one compare fixes it.
  localparam int OFFQ = 1 << (RS + 3);
  localparam int TSH  = RS + 2;
  localparam int QSH  = 59 - RS;
  localparam logic [63:0] T_OFF  = 64'(OFFQ) * 64'(LN2_Q);
  localparam logic [63:0] RINV64 = (64'd1 << 61) / 64'(LN2_Q);
  localparam logic [31:0] RINV   = RINV64[31:0];

  typedef enum logic [3:0] {
    S_IDLE, S_EXP_QEST, S_EXP_REM, S_EXP_FIX, S_EXP_MUL, S_EXP_NDIV, S_EXP_SCALE,
    S_LOG_CHK, S_NORM, S_ZDIV, S_ZSQ, S_LMUL, S_ZY, S_PLN, S_FIN
  } state_t;

  state_t state_r;

  // Item fields held for the whole computation.
  logic signed [31:0]    shift_r;
  logic                  last_r;

  logic [ACC_WIDTH-1:0]  acc_r;
  logic                  sat_r;

  // Exponential working registers.
  logic [63:0]  t_r;
  logic [29:0]  q_r;
  logic [30:0]  r_r;
  logic [31:0]  y_r;
  logic [3:0]   n_r;

  // Log working registers.
  logic [ACC_WIDTH-1:0] x_r;
  logic [6:0]   p_r;
  logic [29:0]  z_r;
  logic [29:0]  w_r;
  logic [3:0]   j_r;
  logic [34:0]  term_r;

  logic signed [31:0] res_sum_r;
  logic               res_empty_r;
  logic               res_sat_r;

  logic               out_valid_r;
  logic signed [31:0] out_log_sum_r;
  logic               out_empty_r;
  logic               out_sat_r;

  // Shared unit requests.
  div_req_t    div_req_r;
  logic [63:0] div_a_r;
  logic [31:0] div_b_r;
  logic        mul_go_r;
  logic [31:0] mul_a_r;
  logic [31:0] mul_b_r;

  logic [63:0] quo;
  logic        div_done;
  logic [63:0] prod;
  logic        mul_done;

  clse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .quo      (quo),
    .done     (div_done)
  );

  clse_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .prod  (prod),
    .done  (mul_done)
  );

  // Range reduction operand: (value - shift) in Q30, offset to stay positive.
  logic signed [63:0] diff64;
  logic [63:0]        t_red;

  always_comb begin
    diff64 = 64'(in_element_value) - 64'(in_column_shift);
    t_red  = 64'(diff64 <<< RS) + T_OFF;
  end

  // Scaling of exp(r) by 2^k into the accumulator format, with clipping.
  logic signed [31:0] s_exp;
  logic signed [31:0] sh_neg;
  logic [5:0]         shamt;
  logic [64:0]        v_up;
  logic [32:0]        v_dn;
  logic [64:0]        v_exp;
  logic               v_clip;
  logic [ACC_WIDTH:0] acc_sum;

  always_comb begin
    s_exp  = $signed({2'b00, q_r}) - 32'(OFFQ) - 32'(RS);
    sh_neg = -s_exp;
    shamt  = sh_neg[5:0];
    v_up   = 65'(y_r) << s_exp[5:0];
    v_dn   = (33'(y_r) + (33'd1 << (shamt - 6'd1))) >> shamt;
    v_clip = 1'b0;
    if (!s_exp[31]) begin
      if (s_exp > 32'sd33 || v_up > ACC_MAX65) begin
        v_clip = 1'b1;
        v_exp  = ACC_MAX65;
      end else begin
        v_exp  = v_up;
      end
    end else if (sh_neg > 32'sd31) begin
      v_exp = '0;
    end else begin
      v_exp = 65'(v_dn);
    end
    acc_sum = (ACC_WIDTH+1)'(acc_r) + (ACC_WIDTH+1)'(v_exp[ACC_WIDTH-1:0]);
  end

  // Final combination: ln(sum) + shift, rounded half up and saturated.
  logic signed [63:0] total;
  logic signed [63:0] rounded;
  logic signed [31:0] res_round;

  always_comb begin
    total   = $signed(prod) + $signed(64'(term_r)) - $signed(FRAC_LN2)
              + (64'(shift_r) <<< RS);
    rounded = (total + (64'sd1 <<< (RS - 1))) >>> RS;
    if (rounded > 64'sd2147483647) begin
      res_round = 32'sh7FFF_FFFF;
    end else if (rounded < -64'sd2147483648) begin
      res_round = 32'sh8000_0000;
    end else begin
      res_round = rounded[31:0];
    end
  end

  // The Horner division by n is a multiply by a reciprocal and a shift.
  logic [31:0] ndiv_q;
  logic [31:0] ynew_exp;
  logic [31:0] ynew_log;
  logic [30:0] mant;

  always_comb begin
    ndiv_q   = 32'(prod >> recip_shift(n_r));
    ynew_exp = ONE_Q + ndiv_q;
    ynew_log = log_coef(j_r) + prod[61:30];
    mant     = x_r[ACC_WIDTH-1 -: 31];
  end

  // Quotient estimate, remainder and the one-step correction of the range reduction.
  logic [29:0] q_est;
  logic [63:0] red_rem;
  logic        red_ge;
  logic [30:0] r_fix;
  logic [29:0] q_fix;

  always_comb begin
    q_est   = 30'(prod >> QSH);
    red_rem = t_r - prod;
    red_ge  = ({1'b0, r_r} >= LN2_Q);
    r_fix   = red_ge ? (r_r - 31'(LN2_Q)) : r_r;
    q_fix   = q_r + 30'(red_ge);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      div_req_r   <= '0;
      mul_go_r    <= 1'b0;
    end else begin
      div_req_r.start <= 1'b0;
      mul_go_r        <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            shift_r <= in_column_shift;
            last_r  <= in_last_in_column;
            if (!in_is_log_zero) begin
              t_r      <= t_red;
              mul_a_r  <= t_red[TSH +: 32];
              mul_b_r  <= RINV;
              mul_go_r <= 1'b1;
              state_r  <= S_EXP_QEST;
            end else if (in_last_in_column) begin
              state_r <= S_LOG_CHK;
            end
          end
        end
        S_EXP_QEST: begin
          if (mul_done) begin
            q_r      <= q_est;
            mul_a_r  <= 32'(q_est);
            mul_b_r  <= LN2_Q;
            mul_go_r <= 1'b1;
            state_r  <= S_EXP_REM;
          end
        end
        S_EXP_REM: begin
          if (mul_done) begin
            r_r     <= red_rem[30:0];
            state_r <= S_EXP_FIX;
          end
        end
        S_EXP_FIX: begin
          q_r      <= q_fix;
          r_r      <= r_fix;
          y_r      <= ONE_Q;
          n_r      <= 4'(EXP_TERMS);
          mul_a_r  <= ONE_Q;
          mul_b_r  <= {1'b0, r_fix};
          mul_go_r <= 1'b1;
          state_r  <= S_EXP_MUL;
        end
        S_EXP_MUL: begin
          if (mul_done) begin
            mul_a_r  <= prod[61:30];
            mul_b_r  <= recip_mul(n_r);
            mul_go_r <= 1'b1;
            state_r  <= S_EXP_NDIV;
          end
        end
        S_EXP_NDIV: begin
          if (mul_done) begin
            y_r <= ynew_exp;
            if (n_r == 4'd1) begin
              state_r <= S_EXP_SCALE;
            end else begin
              n_r      <= n_r - 4'd1;
              mul_a_r  <= ynew_exp;
              mul_b_r  <= {1'b0, r_r};
              mul_go_r <= 1'b1;
              state_r  <= S_EXP_MUL;
            end
          end
        end
        S_EXP_SCALE: begin
          if (acc_sum[ACC_WIDTH]) begin
            acc_r <= {ACC_WIDTH{1'b1}};
            sat_r <= 1'b1;
          end else begin
            acc_r <= acc_sum[ACC_WIDTH-1:0];
            if (v_clip) begin
              sat_r <= 1'b1;
            end
          end
          state_r <= last_r ? S_LOG_CHK : S_IDLE;
        end
        S_LOG_CHK: begin
          if (acc_r == '0) begin
            res_sum_r   <= 32'sh8000_0000;
            res_empty_r <= 1'b1;
            res_sat_r   <= 1'b0;
            state_r     <= S_FIN;
          end else begin
            x_r     <= acc_r;
            p_r     <= TOP_P;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (x_r[ACC_WIDTH-1]) begin
            div_a_r   <= 64'(31'(mant - 31'(ONE_Q))) << IFRAC;
            div_b_r   <= 32'(mant) + ONE_Q;
            div_req_r <= '{start: 1'b1, nbits: 7'd64};
            state_r   <= S_ZDIV;
          end else begin
            x_r <= x_r << 1;
            p_r <= p_r - 7'd1;
          end
        end
        S_ZDIV: begin
          if (div_done) begin
            z_r      <= quo[29:0];
            mul_a_r  <= 32'(quo[29:0]);
            mul_b_r  <= 32'(quo[29:0]);
            mul_go_r <= 1'b1;
            state_r  <= S_ZSQ;
          end
        end
        S_ZSQ: begin
          if (mul_done) begin
            w_r      <= prod[59:30];
            j_r      <= 4'(LOG_TERMS - 1);
            mul_a_r  <= log_coef(4'(LOG_TERMS));
            mul_b_r  <= 32'(prod[59:30]);
            mul_go_r <= 1'b1;
            state_r  <= S_LMUL;
          end
        end
        S_LMUL: begin
          if (mul_done) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= ynew_log;
            if (j_r == 4'd0) begin
              mul_b_r <= 32'(z_r);
              state_r <= S_ZY;
            end else begin
              mul_b_r <= 32'(w_r);
              j_r     <= j_r - 4'd1;
            end
          end
        end
        S_ZY: begin
          if (mul_done) begin
            term_r   <= prod[63:29];
            mul_a_r  <= 32'(p_r);
            mul_b_r  <= LN2_Q;
            mul_go_r <= 1'b1;
            state_r  <= S_PLN;
          end
        end
        S_PLN: begin
          if (mul_done) begin
            res_sum_r   <= res_round;
            res_empty_r <= 1'b0;
            res_sat_r   <= sat_r;
            state_r     <= S_FIN;
          end
        end
        S_FIN: begin
          // Wait until the output register is free, then hand off the item.
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_log_sum_r <= res_sum_r;
            out_empty_r   <= res_empty_r;
            out_sat_r     <= res_sat_r;
            acc_r         <= '0;
            sat_r         <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_log_sum       = out_log_sum_r;
  assign out_column_empty  = out_empty_r;
  assign out_sum_saturated = out_sat_r;

endmodule
